>>> rtl/core/rqwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rqwt_pkg;

  // Widths of the transaction fields.
  localparam int CHAR_W     = 8;
  localparam int FIELD_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_N_ENDS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_N_BASES    = 3'd4;

  // Register values after reset.
  localparam logic [6:0]         RST_QUALITY_OFFSET = 7'd33;
  localparam logic signed [7:0]  RST_MIN_QUALITY    = -8'sd1;
  localparam logic [10:0]        RST_WINDOW_SIZE    = 11'd4;
  localparam logic               RST_STRIP_N_ENDS   = 1'b0;
  localparam logic signed [11:0] RST_MAX_N_BASES    = -12'sd1;

  // Values that switch a test off, and the unknown-base characters.
  localparam logic signed [7:0]  MIN_QUALITY_OFF = -8'sd1;
  localparam logic signed [11:0] MAX_N_OFF       = -12'sd1;
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_N    = 8'h4E;
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_N    = 8'h6E;

endpackage
`default_nettype wire

>>> rtl/core/rqwt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rqwt_in_if;
  logic                         valid;
  logic                         ready;
  logic [rqwt_pkg::CHAR_W-1:0]  base;
  logic [rqwt_pkg::CHAR_W-1:0]  quality_char;
  logic                         last;

  modport source (output valid, base, quality_char, last, input ready);
  modport sink (input valid, base, quality_char, last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rqwt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rqwt_out_if;
  logic                          valid;
  logic                          ready;
  logic [rqwt_pkg::FIELD_W-1:0]  keep_start;
  logic [rqwt_pkg::FIELD_W-1:0]  keep_length;
  logic                          read_affected;
  logic [rqwt_pkg::FIELD_W-1:0]  affected_bases;
  logic                          too_long;

  modport source (output valid, keep_start, keep_length, read_affected, affected_bases,
                  too_long, input ready);
  modport sink (input valid, keep_start, keep_length, read_affected, affected_bases,
                too_long, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rqwt_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rqwt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rqwt_pkg::CFG_IDX_W-1:0]  index;
  logic [rqwt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/read_quality_window_trimmer.sv
// Quality trimmer for one sequencing read at a time. Bases arrive one per transaction on
// the items channel, one per cycle while the block is loading, and are kept with their
// offset-corrected scores in an on-chip store of MAX_READ_LEN entries; bases beyond that
// are dropped and flagged as too long. After the base marked last, the block scans the
// stored read: it sums the first window (w = window size clipped to the read), slides the
// window one base at a time with the window test, searches a low window for the 3' end,
// sums a fresh window after the 5' end is found, then strips N bases at each flank and
// counts the N bases in the kept part. The store is read one entry per port through
// registered read ports. No new read is taken during the scan; the result sits in an
// output register, so loading of the next read may start while it waits.
`timescale 1ns / 1ps
`default_nettype none
module read_quality_window_trimmer #(
  parameter int MAX_READ_LEN = 1024
) (
  input  wire           clk,
  input  wire           rst,
  rqwt_in_if.sink       items,
  rqwt_out_if.source    results,
  rqwt_cfg_if.sink      cfg
);

  localparam int LEN_W  = $clog2(MAX_READ_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_READ_LEN);
  localparam int SUM_W  = LEN_W + 10;
  localparam int CW     = (LEN_W > 11) ? LEN_W : 11;
  localparam int NC_W   = LEN_W + 13;

  typedef enum logic [19:0] {
    ST_LOAD     = 20'b1 << 0,
    ST_PREP     = 20'b1 << 1,
    ST_FILL_RD  = 20'b1 << 2,
    ST_FILL_USE = 20'b1 << 3,
    ST_EVAL     = 20'b1 << 4,
    ST_SRCH_RD  = 20'b1 << 5,
    ST_SRCH_USE = 20'b1 << 6,
    ST_SLD_RD   = 20'b1 << 7,
    ST_SLD_USE  = 20'b1 << 8,
    ST_WDONE    = 20'b1 << 9,
    ST_FLK      = 20'b1 << 10,
    ST_FL5_RD   = 20'b1 << 11,
    ST_FL5_USE  = 20'b1 << 12,
    ST_FL3_RD   = 20'b1 << 13,
    ST_FL3_USE  = 20'b1 << 14,
    ST_NBEG     = 20'b1 << 15,
    ST_NCNT_RD  = 20'b1 << 16,
    ST_NCNT_USE = 20'b1 << 17,
    ST_NDEC     = 20'b1 << 18,
    ST_OUT      = 20'b1 << 19
  } state_t;

  // Configuration registers.
  logic [6:0]         quality_offset;
  logic signed [7:0]  min_quality;
  logic [10:0]        window_size;
  logic               strip_n_ends;
  logic signed [11:0] max_n_bases;

  // Read store: N mark in the top bit, signed score below.
  logic [9:0]        store [MAX_READ_LEN];
  logic [9:0]        dout_a;
  logic [9:0]        dout_b;
  logic [LEN_W-1:0]  addr_a;
  logic [LEN_W-1:0]  addr_b;

  state_t                  state;
  logic [LEN_W-1:0]        read_len;
  logic                    overflow_seen;
  logic [LEN_W-1:0]        w;
  logic [LEN_W-1:0]        i;
  logic [LEN_W-1:0]        f;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] thr;
  logic signed [9:0]       s_first;
  logic                    n5_valid;
  logic                    n3_valid;
  logic [LEN_W-1:0]        n5;
  logic [LEN_W-1:0]        n3;
  logic [LEN_W-1:0]        start;
  logic [LEN_W-1:0]        klen;
  logic                    q_affected;
  logic [LEN_W-1:0]        n_count;

  logic                    item_acc;
  logic                    write_store;
  logic [9:0]              wr_word;
  logic [8:0]              score_in;
  logic                    is_n_in;
  logic signed [9:0]       s_a;
  logic signed [9:0]       s_b;
  logic signed [9:0]       mq10;
  logic                    n_a;
  logic                    last_win;
  logic                    win_hit;
  logic                    win_low;
  logic [CW-1:0]           ws_x;
  logic [CW-1:0]           len_x;
  logic [CW-1:0]           w_clip;
  logic [LEN_W-1:0]        jump_i;

  assign cfg.ready   = 1'b1;
  assign items.ready = (state == ST_LOAD);
  assign item_acc    = items.valid && items.ready;

  // Score is the quality character less the offset, as a 9-bit signed value.
  assign is_n_in     = (items.base == rqwt_pkg::CHAR_UPPER_N) ||
                       (items.base == rqwt_pkg::CHAR_LOWER_N);
  assign score_in    = {1'b0, items.quality_char} - {2'b00, quality_offset};
  assign wr_word     = {is_n_in, score_in};
  assign write_store = item_acc && (read_len < LEN_W'(MAX_READ_LEN));

  // Words read from the store.
  assign s_a  = {dout_a[8], dout_a[8:0]};
  assign s_b  = {dout_b[8], dout_b[8:0]};
  assign n_a  = dout_a[9];
  assign mq10 = {min_quality[7], min_quality[7], min_quality};

  // Window tests.
  assign last_win = (i >= read_len - w);
  assign win_hit  = (sum > thr) && (s_first > mq10);
  assign win_low  = (sum <= thr);
  assign jump_i   = i + w;

  // Window size clipped to between one and the read length.
  assign ws_x   = CW'(window_size);
  assign len_x  = CW'(read_len);
  assign w_clip = (ws_x == '0) ? CW'(1) : ((ws_x > len_x) ? len_x : ws_x);

  // Read addresses follow the state that issues them.
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    case (state)
      ST_FILL_RD: addr_a = i + f;
      ST_SRCH_RD: addr_a = i + f;
      ST_SLD_RD: begin
        addr_a = i + LEN_W'(1);
        addr_b = i + w;
      end
      ST_FL5_RD:  addr_a = start;
      ST_FL3_RD:  addr_a = start + klen - LEN_W'(1);
      ST_NCNT_RD: addr_a = start + f;
      default:    addr_a = '0;
    endcase
  end

  // Store with one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (write_store) begin
      store[read_len[ADDR_W-1:0]] <= wr_word;
    end
    dout_a <= store[addr_a[ADDR_W-1:0]];
    dout_b <= store[addr_b[ADDR_W-1:0]];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      quality_offset <= rqwt_pkg::RST_QUALITY_OFFSET;
      min_quality    <= rqwt_pkg::RST_MIN_QUALITY;
      window_size    <= rqwt_pkg::RST_WINDOW_SIZE;
      strip_n_ends   <= rqwt_pkg::RST_STRIP_N_ENDS;
      max_n_bases    <= rqwt_pkg::RST_MAX_N_BASES;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rqwt_pkg::CFG_QUALITY_OFFSET: quality_offset <= cfg.data[6:0];
        rqwt_pkg::CFG_MIN_QUALITY:    min_quality    <= cfg.data[7:0];
        rqwt_pkg::CFG_WINDOW_SIZE:    window_size    <= cfg.data[10:0];
        rqwt_pkg::CFG_STRIP_N_ENDS:   strip_n_ends   <= cfg.data[0];
        rqwt_pkg::CFG_MAX_N_BASES:    max_n_bases    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Load and scan sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      read_len      <= '0;
      overflow_seen <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      // The output register empties when its transaction completes, unless a new result
      // is loaded in the same cycle.
      if (results.valid && results.ready && (state != ST_OUT)) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (item_acc) begin
            if (write_store) begin
              read_len <= read_len + LEN_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (items.last) begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          w          <= LEN_W'(w_clip);
          start      <= '0;
          klen       <= read_len;
          q_affected <= 1'b0;
          n5_valid   <= 1'b0;
          n3_valid   <= 1'b0;
          i          <= '0;
          f          <= '0;
          sum        <= '0;
          thr        <= SUM_W'($signed(min_quality) * $signed({1'b0, w_clip}));
          if ((min_quality != rqwt_pkg::MIN_QUALITY_OFF) && (read_len != '0)) begin
            state <= ST_FILL_RD;
          end else begin
            state <= ST_FLK;
          end
        end
        ST_FILL_RD: state <= ST_FILL_USE;
        // Sum a whole window; its first score is kept for the 5' test.
        ST_FILL_USE: begin
          sum <= sum + SUM_W'(s_a);
          if (f == '0) begin
            s_first <= s_a;
          end
          f <= f + LEN_W'(1);
          state <= (f + LEN_W'(1) == w) ? ST_EVAL : ST_FILL_RD;
        end
        ST_EVAL: begin
          f <= '0;
          if (win_hit && !n5_valid) begin
            // The 5' end is set once and the scan skips past this window.
            n5_valid <= 1'b1;
            n5       <= i;
            sum      <= '0;
            if (jump_i >= read_len - w) begin
              state <= ST_WDONE;
            end else begin
              i     <= jump_i + LEN_W'(1);
              state <= ST_FILL_RD;
            end
          end else if (!win_hit && win_low && n5_valid) begin
            state <= ST_SRCH_RD;
          end else begin
            state <= last_win ? ST_WDONE : ST_SLD_RD;
          end
        end
        ST_SRCH_RD: state <= ST_SRCH_USE;
        // Look for the first score at or above the threshold in the window.
        ST_SRCH_USE: begin
          if (s_a >= mq10) begin
            n3       <= i + f;
            n3_valid <= 1'b1;
            state    <= last_win ? ST_WDONE : ST_SLD_RD;
          end else if (f + LEN_W'(1) == w) begin
            state <= last_win ? ST_WDONE : ST_SLD_RD;
          end else begin
            f     <= f + LEN_W'(1);
            state <= ST_SRCH_RD;
          end
        end
        ST_SLD_RD: state <= ST_SLD_USE;
        // Move the window by one base.
        ST_SLD_USE: begin
          sum     <= sum - SUM_W'(s_first) + SUM_W'(s_b);
          s_first <= s_a;
          i       <= i + LEN_W'(1);
          state   <= ST_EVAL;
        end
        ST_WDONE: begin
          q_affected <= 1'b1;
          if (!n5_valid) begin
            klen <= '0;
          end else if (!n3_valid) begin
            start <= n5;
            klen  <= read_len - n5;
          end else begin
            start <= n5;
            klen  <= n3 - n5;
          end
          state <= ST_FLK;
        end
        ST_FLK: begin
          state <= (strip_n_ends && (klen != '0)) ? ST_FL5_RD : ST_NBEG;
        end
        ST_FL5_RD: state <= ST_FL5_USE;
        // Strip N bases at the 5' end, stopping at an empty read.
        ST_FL5_USE: begin
          if (n_a) begin
            start <= start + LEN_W'(1);
            klen  <= klen - LEN_W'(1);
            state <= (klen == LEN_W'(1)) ? ST_NBEG : ST_FL5_RD;
          end else begin
            state <= ST_FL3_RD;
          end
        end
        ST_FL3_RD: state <= ST_FL3_USE;
        // Strip N bases at the 3' end.
        ST_FL3_USE: begin
          if (n_a) begin
            klen  <= klen - LEN_W'(1);
            state <= (klen == LEN_W'(1)) ? ST_NBEG : ST_FL3_RD;
          end else begin
            state <= ST_NBEG;
          end
        end
        ST_NBEG: begin
          f       <= '0;
          n_count <= '0;
          if ((max_n_bases != rqwt_pkg::MAX_N_OFF) && (klen != '0)) begin
            state <= ST_NCNT_RD;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_NCNT_RD: state <= ST_NCNT_USE;
        // Count the N bases that remain in the kept part.
        ST_NCNT_USE: begin
          n_count <= n_count + LEN_W'(n_a);
          f       <= f + LEN_W'(1);
          state   <= (f + LEN_W'(1) == klen) ? ST_NDEC : ST_NCNT_RD;
        end
        ST_NDEC: begin
          if ($signed(NC_W'({1'b0, n_count})) > NC_W'(max_n_bases)) begin
            klen <= '0;
          end
          state <= ST_OUT;
        end
        // Hand the result over once the output register is free.
        ST_OUT: begin
          if (!results.valid || results.ready) begin
            results.valid          <= 1'b1;
            results.keep_start     <= (klen == '0) ? '0 : rqwt_pkg::FIELD_W'(start);
            results.keep_length    <= rqwt_pkg::FIELD_W'(klen);
            results.read_affected  <= q_affected && (klen != read_len);
            results.affected_bases <= rqwt_pkg::FIELD_W'(read_len - klen);
            results.too_long       <= overflow_seen;
            read_len               <= '0;
            overflow_seen          <= 1'b0;
            state                  <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_read_quality_window_trimmer.sv
`timescale 1ns / 1ps
module tb_read_quality_window_trimmer;

  localparam int STORE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 800;

  typedef struct packed {
    logic [rqwt_pkg::CHAR_W-1:0] base;
    logic [rqwt_pkg::CHAR_W-1:0] qual;
    logic                        last;
  } base_item_t;

  typedef struct packed {
    logic [rqwt_pkg::FIELD_W-1:0] start;
    logic [rqwt_pkg::FIELD_W-1:0] length;
    logic                         affected;
    logic [rqwt_pkg::FIELD_W-1:0] removed;
    logic                         too_long;
  } trim_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rqwt_in_if  items ();
  rqwt_out_if results ();
  rqwt_cfg_if cfg ();

  read_quality_window_trimmer DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items.sink),
    .results (results.source),
    .cfg     (cfg.sink)
  );

  always #1 clk = ~clk;

  base_item_t   pending_bases[$];
  trim_result_t expected_trims[$];

  // Mirror of the block's registers and read store.
  int   cur_offset = rqwt_pkg::RST_QUALITY_OFFSET;
  int   cur_min_q  = rqwt_pkg::RST_MIN_QUALITY;
  int   cur_window = rqwt_pkg::RST_WINDOW_SIZE;
  bit   cur_flank  = rqwt_pkg::RST_STRIP_N_ENDS;
  int   cur_max_n  = rqwt_pkg::RST_MAX_N_BASES;
  int   score_mem[STORE_DEPTH];
  bit   n_mem[STORE_DEPTH];
  int   stored_len = 0;
  bit   overflowed = 1'b0;

  int   errors = 0;
  int   cycles = 0;
  int   total_bases = 0;
  int   reads_checked = 0;
  int   reads_emptied = 0;
  int   overflow_reads = 0;
  bit   in_fire = 1'b0;
  bit   out_fire = 1'b0;
  bit   no_gaps = 1'b0;
  bit   long_hold_req = 1'b0;
  bit   long_hold_done = 1'b0;
  int   send_gap = 0;
  int   recv_wait = 0;
  int   hold_cycles = 0;

  // Trimming decision for the read held in the mirror store.
  task automatic trim_stored_read();
    trim_result_t r;
    int len, start, removed, i, k, w, n5, n3, fin, cnt, sum, thr, cnt_n;
    bit hit;
    bit affected;
    len = stored_len;
    start = 0;
    removed = 0;
    affected = 1'b0;
    if (cur_min_q != rqwt_pkg::MIN_QUALITY_OFF && len > 0) begin
      w = cur_window;
      if (w < 1) w = 1;
      if (w > len) w = len;
      n5 = -1;
      n3 = -1;
      i = 0;
      while (i < len) begin
        fin = (i + w > len) ? len : i + w;
        cnt = fin - i;
        sum = 0;
        for (k = i; k < fin; k++) sum += score_mem[k];
        thr = cur_min_q * cnt;
        if (sum > thr && score_mem[i] > cur_min_q) begin
          if (n5 < 0) begin
            n5 = i;
            i += cnt;
          end
        end else if (sum <= thr && n5 >= 0) begin
          hit = 1'b0;
          for (k = 0; k < w && i + k < len && !hit; k++) begin
            if (score_mem[i + k] >= cur_min_q) begin
              n3 = i + k;
              hit = 1'b1;
            end
          end
        end
        if (i >= len - w) break;
        i++;
      end
      affected = 1'b1;
      if (n5 < 0) begin
        removed += len;
        len = 0;
      end else if (n3 < 0) begin
        removed += n5;
        start = n5;
        len -= n5;
      end else begin
        removed += (stored_len - n3) + n5;
        start = n5;
        len = n3 - n5;
      end
    end
    if (cur_flank && len > 0) begin
      while (len > 0 && n_mem[start]) begin
        start++;
        len--;
        removed++;
      end
      while (len > 0 && n_mem[start + len - 1]) begin
        len--;
        removed++;
      end
    end
    if (cur_max_n != rqwt_pkg::MAX_N_OFF && len > 0) begin
      cnt_n = 0;
      for (k = 0; k < len; k++) cnt_n += n_mem[start + k];
      if (cnt_n > cur_max_n) begin
        removed += len;
        len = 0;
      end
    end
    if (len == stored_len) affected = 1'b0;
    if (len == 0) start = 0;
    r.start = start[rqwt_pkg::FIELD_W-1:0];
    r.length = len[rqwt_pkg::FIELD_W-1:0];
    r.affected = affected;
    r.removed = removed[rqwt_pkg::FIELD_W-1:0];
    r.too_long = overflowed;
    expected_trims = {expected_trims, r};
    if (overflowed) overflow_reads++;
    if (len == 0) reads_emptied++;
    stored_len = 0;
    overflowed = 1'b0;
  endtask

  // Monitor: follows every transaction at the rising edge.
  always @(posedge clk) begin
    trim_result_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("tb_read_quality_window_trimmer: FAIL");
      $finish;
    end
    in_fire = !rst && items.valid && items.ready;
    out_fire = !rst && results.valid && results.ready;
    if (!rst && cfg.valid && cfg.ready) begin
      case (cfg.index)
        rqwt_pkg::CFG_QUALITY_OFFSET: cur_offset = cfg.data[6:0];
        rqwt_pkg::CFG_MIN_QUALITY:    cur_min_q = $signed(cfg.data[7:0]);
        rqwt_pkg::CFG_WINDOW_SIZE:    cur_window = cfg.data[10:0];
        rqwt_pkg::CFG_STRIP_N_ENDS:   cur_flank = cfg.data[0];
        rqwt_pkg::CFG_MAX_N_BASES:    cur_max_n = $signed(cfg.data[11:0]);
        default: ;
      endcase
    end
    if (in_fire) begin
      if (stored_len < STORE_DEPTH) begin
        n_mem[stored_len] = (items.base == rqwt_pkg::CHAR_UPPER_N) ||
                            (items.base == rqwt_pkg::CHAR_LOWER_N);
        score_mem[stored_len] = int'(items.quality_char) - cur_offset;
        stored_len++;
      end else begin
        overflowed = 1'b1;
      end
      if (items.last) trim_stored_read();
    end
    if (out_fire) begin
      got = '{results.keep_start, results.keep_length, results.read_affected,
              results.affected_bases, results.too_long};
      if (expected_trims.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: %p", $time, got);
      end else begin
        want = expected_trims.pop_front();
        reads_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  // Base driver: takes items from the pending queue with a random gap unless gaps are off.
  always @(negedge clk) begin
    base_item_t it;
    if (rst) begin
      items.valid <= 1'b0;
      items.base <= '0;
      items.quality_char <= '0;
      items.last <= 1'b0;
    end else if (!items.valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        items.valid <= 1'b0;
      end else if (pending_bases.size() > 0) begin
        it = pending_bases.pop_front();
        items.base <= it.base;
        items.quality_char <= it.qual;
        items.last <= it.last;
        items.valid <= 1'b1;
        send_gap = no_gaps ? 0 : $urandom_range(0, 9);
      end else begin
        items.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (out_fire) recv_wait = no_gaps ? 0 : $urandom_range(0, 9);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_cycles = 3000;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        results.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [rqwt_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value[rqwt_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_all(input int offset, input int min_q, input int window, input int flank,
                         input int max_n);
    write_reg(rqwt_pkg::CFG_QUALITY_OFFSET, offset);
    write_reg(rqwt_pkg::CFG_MIN_QUALITY, min_q);
    write_reg(rqwt_pkg::CFG_WINDOW_SIZE, window);
    write_reg(rqwt_pkg::CFG_STRIP_N_ENDS, flank);
    write_reg(rqwt_pkg::CFG_MAX_N_BASES, max_n);
  endtask

  task automatic add_base(input logic [7:0] b, input logic [7:0] q, input bit is_last);
    base_item_t it;
    it.base = b;
    it.qual = q;
    it.last = is_last;
    pending_bases = {pending_bases, it};
    total_bases++;
  endtask

  // One random read: mostly plausible bases and scores near the threshold.
  task automatic add_random_read(input int len, input int offset, input int min_q);
    logic [7:0] b, q;
    int pick, centre;
    centre = (min_q < 0) ? 20 : min_q;
    for (int j = 0; j < len; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) b = rqwt_pkg::CHAR_UPPER_N;
      else if (pick < 22) b = rqwt_pkg::CHAR_LOWER_N;
      else if (pick < 35) b = 8'($urandom_range(0, 255));
      else case ($urandom_range(0, 3))
        0: b = "A";
        1: b = "C";
        2: b = "G";
        default: b = "T";
      endcase
      if ($urandom_range(0, 9) == 0) q = 8'($urandom_range(0, 255));
      else q = 8'(offset + centre + int'($urandom_range(0, 24)) - 12);
      add_base(b, q, j == len - 1);
    end
  endtask

  // Waits until every read has been answered and the block is quiet again.
  task automatic drain();
    while (pending_bases.size() > 0 || items.valid || expected_trims.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    int phase, offset, min_q, window, flank, max_n, phase_end;
    items.valid = 1'b0;
    items.base = '0;
    items.quality_char = '0;
    items.last = 1'b0;
    results.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed reads at the reset settings: short reads and extreme characters.
    add_base(rqwt_pkg::CHAR_UPPER_N, 8'h00, 1'b1);
    add_base(8'hFF, 8'hFF, 1'b0);
    add_base(8'h00, 8'h00, 1'b1);
    add_base(rqwt_pkg::CHAR_LOWER_N, 8'h80, 1'b0);
    add_base("A", 8'h7F, 1'b1);
    drain();

    // Quality trimming with flank stripping: all-N read, a good read with N flanks,
    // a read too poor to keep and a read with a good core between poor ends.
    set_all(33, 20, 4, 1, 0);
    for (int j = 0; j < 4; j++) add_base(rqwt_pkg::CHAR_UPPER_N, 8'd80, j == 3);
    add_base(rqwt_pkg::CHAR_LOWER_N, 8'd80, 1'b0);
    for (int j = 0; j < 4; j++) add_base("G", 8'd75, 1'b0);
    add_base(rqwt_pkg::CHAR_UPPER_N, 8'd80, 1'b1);
    for (int j = 0; j < 3; j++) add_base("C", 8'd35, j == 2);
    add_base("T", 8'd40, 1'b0);
    for (int j = 0; j < 5; j++) add_base("A", 8'd70, 1'b0);
    for (int j = 0; j < 3; j++) add_base("A", 8'd36, j == 2);
    drain();

    // Extreme settings, including window zero and the lowest threshold, then random settings.
    for (phase = 0; total_bases < ITEM_TARGET; phase++) begin
      case (phase)
        0: begin offset = 0;   min_q = -128; window = 0;    flank = 1; max_n = -2048; end
        1: begin offset = 127; min_q = 127;  window = 1024; flank = 1; max_n = 1024;  end
        2: begin offset = 64;  min_q = 30;   window = 2047; flank = 0; max_n = 3;     end
        3: begin offset = 33;  min_q = -1;   window = 4;    flank = 1; max_n = 2;     end
        4: begin offset = 33;  min_q = 0;    window = 1;    flank = 0; max_n = 0;     end
        default: begin
          offset = ($urandom_range(0, 1) != 0) ? 33 : 64;
          min_q = ($urandom_range(0, 5) == 0) ? -1 : $urandom_range(0, 40);
          window = $urandom_range(1, 8);
          flank = $urandom_range(0, 1);
          max_n = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 5);
        end
      endcase
      set_all(offset, min_q, window, flank, max_n);
      no_gaps = (phase % 4 == 2);
      if (phase == 5) long_hold_req = 1'b1;
      phase_end = total_bases + 90;
      while (total_bases < phase_end) add_random_read($urandom_range(1, 24), offset, min_q);
      if (phase == 1) add_random_read($urandom_range(40, 80), offset, min_q);
      drain();
    end

    $display("Checked %0d reads over %0d bases and %0d settings.", reads_checked, total_bases,
             phase + 2);
    $display("Reads emptied: %0d, reads over the store size: %0d.", reads_emptied,
             overflow_reads);
    if (errors == 0) begin
      $display("tb_read_quality_window_trimmer: PASS");
    end else begin
      $display("tb_read_quality_window_trimmer: FAIL");
    end
    $finish;
  end

endmodule
